>>> rtl/adsr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the linear ADSR envelope level block.
package adsr_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned LEN_W     = 24;
	localparam int unsigned LVL_W     = 17;
	localparam int unsigned PROD_W    = LVL_W + LEN_W;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [LVL_W-1:0] UNITY = LVL_W'(65536);

	localparam logic [REG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SUSTAIN_LEN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE_LEN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SUS_LEVEL   = 3'd4;

	localparam logic [LEN_W-1:0] ATTACK_LEN_RST  = LEN_W'(4800);
	localparam logic [LEN_W-1:0] DECAY_LEN_RST   = LEN_W'(4800);
	localparam logic [LEN_W-1:0] SUSTAIN_LEN_RST = LEN_W'(38400);
	localparam logic [LEN_W-1:0] RELEASE_LEN_RST = LEN_W'(9600);
	localparam logic [LVL_W-1:0] SUS_LEVEL_RST   = LVL_W'(32768);

	// sus_level holds the value after adsr_envelope_level saturates it to unity with sat_level
	typedef struct packed {
		logic [LEN_W-1:0] attack_len;
		logic [LEN_W-1:0] decay_len;
		logic [LEN_W-1:0] sustain_len;
		logic [LEN_W-1:0] release_len;
		logic [LVL_W-1:0] sus_level;
	} cfg_t;

	// level = base + floor(mul_a * mul_b / den)
	typedef struct packed {
		logic [LVL_W-1:0] mul_a;
		logic [LEN_W-1:0] mul_b;
		logic [LEN_W-1:0] den;
		logic [LVL_W-1:0] base;
	} mul_op_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [LEN_W-1:0]  den;
		logic [LVL_W-1:0]  base;
	} div_op_t;

	function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] lvl);
		sat_level = (lvl > UNITY) ? UNITY : lvl;
	endfunction

endpackage

>>> rtl/adsr_seg.sv
`timescale 1ns / 1ps
// Segment decode: three stages that locate the tick and build the divide operands.
module adsr_seg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid_in,
	input  logic [adsr_pkg::TIME_W-1:0]   elapsed_in,
	input  adsr_pkg::cfg_t                cfg,
	output logic                          valid_out,
	output adsr_pkg::mul_op_t             op_out
);

	logic                          v_s1, v_s2, v_s3;
	logic                          att_s1, att_s2;
	logic [adsr_pkg::TIME_W-1:0]   o1_s1;
	logic [adsr_pkg::LEN_W:0]      dh_s1;
	logic [adsr_pkg::LEN_W-1:0]    e_s1, e_s2;
	logic                          dec_s2, sus_s2;
	logic [adsr_pkg::TIME_W-1:0]   o3_s2;
	logic [adsr_pkg::LEN_W-1:0]    dmo_s2;
	adsr_pkg::mul_op_t             op_s3;
	adsr_pkg::mul_op_t             op_d;
	logic                          rel;
	logic [adsr_pkg::LEN_W-1:0]    rmo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: attack test, offset past attack
	always_ff @(posedge clk) begin
		if (adv) begin
			att_s1 <= elapsed_in <= adsr_pkg::TIME_W'(cfg.attack_len);
			o1_s1  <= elapsed_in - adsr_pkg::TIME_W'(cfg.attack_len);
			dh_s1  <= (adsr_pkg::LEN_W+1)'(cfg.decay_len)
				+ (adsr_pkg::LEN_W+1)'(cfg.sustain_len);
			e_s1   <= elapsed_in[adsr_pkg::LEN_W-1:0];
		end
	end

	// stage 2: decay and sustain tests, offset past sustain
	always_ff @(posedge clk) begin
		if (adv) begin
			att_s2 <= att_s1;
			e_s2   <= e_s1;
			dec_s2 <= !att_s1 && (o1_s1 <= adsr_pkg::TIME_W'(cfg.decay_len));
			sus_s2 <= !att_s1 && (o1_s1 > adsr_pkg::TIME_W'(cfg.decay_len))
				&& (o1_s1 <= adsr_pkg::TIME_W'(dh_s1));
			o3_s2  <= o1_s1 - adsr_pkg::TIME_W'(dh_s1);
			dmo_s2 <= cfg.decay_len - o1_s1[adsr_pkg::LEN_W-1:0];
		end
	end

	// stage 3: release test and operand selection
	assign rel = !att_s2 && !dec_s2 && !sus_s2
		&& (o3_s2 <= adsr_pkg::TIME_W'(cfg.release_len));
	assign rmo = cfg.release_len - o3_s2[adsr_pkg::LEN_W-1:0];

	always_comb begin
		op_d.mul_a = '0;
		op_d.mul_b = '0;
		op_d.den   = adsr_pkg::LEN_W'(1);
		op_d.base  = '0;
		if (att_s2) begin
			op_d.mul_a = adsr_pkg::UNITY;
			if (cfg.attack_len == '0) begin
				op_d.mul_b = adsr_pkg::LEN_W'(1);
			end else begin
				op_d.mul_b = e_s2;
				op_d.den   = cfg.attack_len;
			end
		end else if (dec_s2) begin
			op_d.mul_a = adsr_pkg::UNITY - cfg.sus_level;
			op_d.mul_b = dmo_s2;
			op_d.base  = cfg.sus_level;
			if (cfg.decay_len != '0) begin
				op_d.den = cfg.decay_len;
			end
		end else if (sus_s2) begin
			op_d.base = cfg.sus_level;
		end else if (rel) begin
			op_d.mul_a = cfg.sus_level;
			op_d.mul_b = rmo;
			if (cfg.release_len != '0) begin
				op_d.den = cfg.release_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_d;
		end
	end

	assign valid_out = v_s3;
	assign op_out    = op_s3;

endmodule

>>> rtl/adsr_mul.sv
`timescale 1ns / 1ps
// Product stage: 17 x 24 multiply of the numerator operands.
module adsr_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_in,
	input  adsr_pkg::mul_op_t op_in,
	output logic              valid_out,
	output adsr_pkg::div_op_t op_out
);

	logic              v_s4;
	adsr_pkg::div_op_t op_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4.prod <= adsr_pkg::PROD_W'(op_in.mul_a) * adsr_pkg::PROD_W'(op_in.mul_b);
			op_s4.den  <= op_in.den;
			op_s4.base <= op_in.base;
		end
	end

	assign valid_out = v_s4;
	assign op_out    = op_s4;

endmodule

>>> rtl/adsr_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, MSB first.
module adsr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         valid_in,
	input  adsr_pkg::div_op_t            op_in,
	output logic                         valid_out,
	output logic [adsr_pkg::LVL_W-1:0]   quo_out,
	output logic [adsr_pkg::LVL_W-1:0]   base_out
);

	localparam int unsigned NSTEP  = adsr_pkg::LVL_W;
	localparam int unsigned DIFF_W = adsr_pkg::PROD_W + 1;

	logic                         v_s    [NSTEP];
	logic [adsr_pkg::PROD_W-1:0]  rem_s  [NSTEP-1];
	logic [adsr_pkg::LEN_W-1:0]   den_s  [NSTEP-1];
	logic [adsr_pkg::LVL_W-1:0]   quo_s  [NSTEP];
	logic [adsr_pkg::LVL_W-1:0]   base_s [NSTEP];

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int unsigned SH = NSTEP - 1 - k;
		logic                         v_prev;
		logic [adsr_pkg::PROD_W-1:0]  rem_prev;
		logic [adsr_pkg::LEN_W-1:0]   den_prev;
		logic [adsr_pkg::LVL_W-1:0]   quo_prev;
		logic [adsr_pkg::LVL_W-1:0]   base_prev;
		logic [DIFF_W-1:0]            trial;

		if (k == 0) begin : g_first
			assign v_prev    = valid_in;
			assign rem_prev  = op_in.prod;
			assign den_prev  = op_in.den;
			assign quo_prev  = '0;
			assign base_prev = op_in.base;
		end else begin : g_next
			assign v_prev    = v_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign den_prev  = den_s[k-1];
			assign quo_prev  = quo_s[k-1];
			assign base_prev = base_s[k-1];
		end

		assign trial = DIFF_W'(rem_prev) - (DIFF_W'(den_prev) << SH);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[k]  <= {quo_prev[adsr_pkg::LVL_W-2:0], ~trial[DIFF_W-1]};
				base_s[k] <= base_prev;
			end
		end

		if (k < NSTEP - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= trial[DIFF_W-1] ? rem_prev : trial[adsr_pkg::PROD_W-1:0];
					den_s[k] <= den_prev;
				end
			end
		end
	end

	assign valid_out = v_s[NSTEP-1];
	assign quo_out   = quo_s[NSTEP-1];
	assign base_out  = base_s[NSTEP-1];

endmodule

>>> rtl/adsr_envelope_level.sv
`timescale 1ns / 1ps
// Linear ADSR envelope level: maps ticks since note start to a Q1.16 level.
// Throughput: one item per cycle when not stalled; 3 decode stages, 1 multiply, 17 divider stages, output.
// The whole pipeline advances together; an output stall while a result is valid holds every stage.
// Reset clears all valid bits and loads the default segment lengths and level.
module adsr_envelope_level (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [adsr_pkg::TIME_W-1:0]     elapsed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [adsr_pkg::LVL_W-1:0]      level,
	input  logic                            wr_en,
	input  logic [adsr_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [adsr_pkg::LEN_W-1:0]      wr_data
);

	logic [adsr_pkg::LEN_W-1:0] attack_len_q, decay_len_q, sustain_len_q, release_len_q;
	logic [adsr_pkg::LVL_W-1:0] sus_level_q;
	adsr_pkg::cfg_t             cfg;
	logic                       adv;
	logic                       seg_valid, mul_valid, div_valid;
	adsr_pkg::mul_op_t          seg_op;
	adsr_pkg::div_op_t          mul_op;
	logic [adsr_pkg::LVL_W-1:0] div_quo, div_base;
	logic                       out_valid_q;
	logic [adsr_pkg::LVL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= adsr_pkg::ATTACK_LEN_RST;
			decay_len_q   <= adsr_pkg::DECAY_LEN_RST;
			sustain_len_q <= adsr_pkg::SUSTAIN_LEN_RST;
			release_len_q <= adsr_pkg::RELEASE_LEN_RST;
			sus_level_q   <= adsr_pkg::SUS_LEVEL_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				adsr_pkg::REG_ATTACK_LEN:  attack_len_q  <= wr_data;
				adsr_pkg::REG_DECAY_LEN:   decay_len_q   <= wr_data;
				adsr_pkg::REG_SUSTAIN_LEN: sustain_len_q <= wr_data;
				adsr_pkg::REG_RELEASE_LEN: release_len_q <= wr_data;
				adsr_pkg::REG_SUS_LEVEL:
					sus_level_q <= wr_data[adsr_pkg::LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.attack_len  = attack_len_q;
		cfg.decay_len   = decay_len_q;
		cfg.sustain_len = sustain_len_q;
		cfg.release_len = release_len_q;
		cfg.sus_level   = adsr_pkg::sat_level(sus_level_q);
	end

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	adsr_seg u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (in_valid),
		.elapsed_in(elapsed),
		.cfg       (cfg),
		.valid_out (seg_valid),
		.op_out    (seg_op)
	);

	adsr_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (seg_valid),
		.op_in    (seg_op),
		.valid_out(mul_valid),
		.op_out   (mul_op)
	);

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (mul_valid),
		.op_in    (mul_op),
		.valid_out(div_valid),
		.quo_out  (div_quo),
		.base_out (div_base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q <= div_base + div_quo;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= adsr_pkg::UNITY)
		else $error("envelope level above unity");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && !adv |=> div_valid)
		else $error("divider result lost during output stall");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(div_valid))
		else $error("result appeared with no divider result behind it");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for adsr_envelope_level: directed table, then randomised register settings and times.
module tb_top;

	localparam int unsigned TIME_W       = adsr_pkg::TIME_W;
	localparam int unsigned LEN_W        = adsr_pkg::LEN_W;
	localparam int unsigned LVL_W        = adsr_pkg::LVL_W;
	localparam int unsigned REG_IDX_W    = adsr_pkg::REG_IDX_W;
	localparam int unsigned LATENCY      = 22;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned PHASES       = 9;
	localparam int unsigned PHASE_ITEMS  = 200;
	localparam int unsigned CALM_PHASE   = 4;
	localparam logic [REG_IDX_W-1:0] REG_NONE_LO = adsr_pkg::REG_SUS_LEVEL + 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NONE_HI = '1;

	typedef enum {STEP_ITEM, STEP_WRITE} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		logic [REG_IDX_W-1:0] idx;
		logic [LEN_W-1:0]     data;
		logic [TIME_W-1:0]    t;
		bit                   typed;
		logic [LVL_W-1:0]     lvl;
	} step_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [TIME_W-1:0]    elapsed   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LVL_W-1:0]     level;
	logic                 wr_en     = 1'b0;
	logic [REG_IDX_W-1:0] wr_index  = '0;
	logic [LEN_W-1:0]     wr_data   = '0;

	// shadow copy of the block's registers
	logic [LEN_W-1:0] atk_len  = adsr_pkg::ATTACK_LEN_RST;
	logic [LEN_W-1:0] dec_len  = adsr_pkg::DECAY_LEN_RST;
	logic [LEN_W-1:0] hold_len = adsr_pkg::SUSTAIN_LEN_RST;
	logic [LEN_W-1:0] rel_len  = adsr_pkg::RELEASE_LEN_RST;
	logic [LVL_W-1:0] sus_lvl  = adsr_pkg::SUS_LEVEL_RST;

	logic [LVL_W-1:0] levels_due[$];
	logic [LVL_W-1:0] want;
	step_t            plan[$];
	bit               calm = 1'b0;
	int unsigned      sent_count = 0;
	int unsigned      level_count = 0;
	int unsigned      fail_count = 0;
	int unsigned      setting_count = 0;
	int unsigned      quiet_cycles = 0;

	adsr_envelope_level u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.elapsed   (elapsed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level     (level),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [LVL_W-1:0] envelope_at(input logic [TIME_W-1:0] t);
		longint unsigned e, s, a, d, h, r, o, u;
		e = t;
		u = adsr_pkg::UNITY;
		s = (sus_lvl > adsr_pkg::UNITY) ? u : longint'(sus_lvl);
		a = atk_len;
		d = dec_len;
		h = hold_len;
		r = rel_len;
		if (e <= a) begin
			if (a == 0)
				return adsr_pkg::UNITY;
			return LVL_W'((e * u) / a);
		end
		o = e - a;
		if (o <= d) begin
			if (d == 0)
				return LVL_W'(s);
			return LVL_W'(s + ((u - s) * (d - o)) / d);
		end
		o = o - d;
		if (o <= h)
			return LVL_W'(s);
		o = o - h;
		if (o <= r && r != 0)
			return LVL_W'((s * (r - o)) / r);
		return '0;
	endfunction

	function automatic void shadow_write(input logic [REG_IDX_W-1:0] idx,
			input logic [LEN_W-1:0] data);
		case (idx)
			adsr_pkg::REG_ATTACK_LEN:  atk_len = data;
			adsr_pkg::REG_DECAY_LEN:   dec_len = data;
			adsr_pkg::REG_SUSTAIN_LEN: hold_len = data;
			adsr_pkg::REG_RELEASE_LEN: rel_len = data;
			adsr_pkg::REG_SUS_LEVEL:   sus_lvl = data[LVL_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return LEN_W'($urandom_range(16, 1));
			4, 5, 6: return LEN_W'($urandom_range(2000, 1));
			7, 8: return LEN_W'($urandom_range(65535, 0));
			default: return LEN_W'($urandom);
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_sustain();
		case ($urandom_range(7))
			0: return '0;
			1: return LEN_W'(adsr_pkg::UNITY);
			2: return LEN_W'($urandom_range(131071, 65537));
			3: return LEN_W'($urandom);
			default: return LEN_W'($urandom_range(65536, 0));
		endcase
	endfunction

	// mostly times inside the envelope, with segment edges and full-range values mixed in
	function automatic logic [TIME_W-1:0] pick_time();
		longint unsigned span, b;
		int unsigned sel;
		span = longint'(atk_len) + dec_len + hold_len + rel_len;
		sel = $urandom_range(99);
		if (sel < 20)
			return $urandom;
		if (sel < 40) begin
			case ($urandom_range(4))
				0: b = 0;
				1: b = atk_len;
				2: b = longint'(atk_len) + dec_len;
				3: b = longint'(atk_len) + dec_len + hold_len;
				default: b = span;
			endcase
			return TIME_W'(b + $urandom_range(2) - 1);
		end
		return $urandom_range(TIME_W'(span + span / 8 + 2), 0);
	endfunction

	function automatic void probe(input logic [TIME_W-1:0] t);
		plan.push_back('{STEP_ITEM, '0, '0, t, 1'b0, '0});
	endfunction

	function automatic void probe_is(input logic [TIME_W-1:0] t, input logic [LVL_W-1:0] lvl);
		plan.push_back('{STEP_ITEM, '0, '0, t, 1'b1, lvl});
	endfunction

	function automatic void poke(input logic [REG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
		plan.push_back('{STEP_WRITE, idx, data, '0, 1'b0, '0});
	endfunction

	task automatic note_mismatch(input string what, input logic [LVL_W-1:0] got,
			input logic [LVL_W-1:0] exp_lvl);
		$display("MISMATCH %s: level %0d, expected %0d, at %0t", what, got, exp_lvl, $realtime);
		fail_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (levels_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		shadow_write(idx, data);
		@(posedge clk);
	endtask

	task automatic send_time(input logic [TIME_W-1:0] t, input bit typed,
			input logic [LVL_W-1:0] lvl);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		levels_due.push_back(typed ? lvl : envelope_at(t));
		sent_count++;
	endtask

	task automatic new_setting();
		drain();
		write_reg(adsr_pkg::REG_ATTACK_LEN, pick_len());
		write_reg(adsr_pkg::REG_DECAY_LEN, pick_len());
		write_reg(adsr_pkg::REG_SUSTAIN_LEN, pick_len());
		write_reg(adsr_pkg::REG_RELEASE_LEN, pick_len());
		write_reg(adsr_pkg::REG_SUS_LEVEL, pick_sustain());
		if ($urandom_range(2) == 0)
			write_reg(REG_IDX_W'($urandom_range(REG_NONE_HI, REG_NONE_LO)), LEN_W'($urandom));
		wr_en <= 1'b0;
		setting_count++;
	endtask

	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			level_count++;
			if (levels_due.size() == 0) begin
				note_mismatch("unexpected transfer", level, '0);
			end else begin
				want = levels_due.pop_front();
				if (level !== want)
					note_mismatch("level", level, want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("adsr_envelope_level test failed");
			$finish;
		end
	end

	initial begin
		// reset settings: A 4800, D 4800, H 38400, R 9600, S half
		probe_is(0, 0);
		probe_is(2400, 32768);
		probe_is(4800, adsr_pkg::UNITY);
		probe(4801);
		probe(7200);
		probe_is(9600, 32768);
		probe_is(48000, 32768);
		probe(48001);
		probe(52800);
		probe_is(57600, 0);
		probe_is('1, 0);
		// longest segments, zero sustain
		poke(adsr_pkg::REG_ATTACK_LEN, '1);
		poke(adsr_pkg::REG_DECAY_LEN, '1);
		poke(adsr_pkg::REG_SUSTAIN_LEN, '1);
		poke(adsr_pkg::REG_RELEASE_LEN, '1);
		poke(adsr_pkg::REG_SUS_LEVEL, '0);
		probe_is(0, 0);
		probe_is(32'hFF_FFFF, adsr_pkg::UNITY);
		probe(32'h100_0000);
		probe_is(32'h1FF_FFFE, 0);
		probe(40000000);
		probe_is('1, 0);
		// zero-length segments, sustain above unity, stray index ignored
		poke(adsr_pkg::REG_ATTACK_LEN, '0);
		poke(adsr_pkg::REG_DECAY_LEN, '0);
		poke(adsr_pkg::REG_SUSTAIN_LEN, '0);
		poke(adsr_pkg::REG_RELEASE_LEN, '0);
		poke(adsr_pkg::REG_SUS_LEVEL, 24'd65537);
		poke(REG_NONE_LO, '1);
		probe_is(0, adsr_pkg::UNITY);
		probe_is(1, 0);
		// over-wide sustain data is masked then saturated
		poke(adsr_pkg::REG_ATTACK_LEN, 24'd1);
		poke(adsr_pkg::REG_RELEASE_LEN, 24'd1);
		poke(adsr_pkg::REG_SUS_LEVEL, '1);
		poke(REG_NONE_HI, '0);
		probe_is(1, adsr_pkg::UNITY);
		probe_is(2, 0);
		probe_is(0, 0);
		poke(adsr_pkg::REG_ATTACK_LEN, 24'd3);
		poke(adsr_pkg::REG_DECAY_LEN, 24'd3);
		poke(adsr_pkg::REG_SUSTAIN_LEN, 24'd2);
		poke(adsr_pkg::REG_RELEASE_LEN, 24'd3);
		poke(adsr_pkg::REG_SUS_LEVEL, 24'd100);
		probe(4);
		probe_is(8, 100);
		probe(9);
		probe_is(12, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				if (i == 0 || plan[i-1].kind != STEP_WRITE) begin
					drain();
					setting_count++;
				end
				write_reg(plan[i].idx, plan[i].data);
				if (i == plan.size() - 1 || plan[i+1].kind != STEP_WRITE)
					wr_en <= 1'b0;
			end else begin
				send_time(plan[i].t, plan[i].typed, plan[i].lvl);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			new_setting();
			calm = (p == CALM_PHASE);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == PHASE_ITEMS / 2)
					drain();
				send_time(pick_time(), 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain();
		repeat (LATENCY + 8) @(posedge clk);
		$display("%0d envelope times sent, %0d levels compared over %0d register settings",
			sent_count, level_count, setting_count + 1);
		$display("segment edges, zero-length segments and saturated sustain; %0d mismatches",
			fail_count);
		if (fail_count == 0) begin
			$display("adsr_envelope_level test passed");
		end else begin
			$display("adsr_envelope_level test failed");
		end
		$finish;
	end

endmodule
